// ----- hw/rtl/apt_pkg.sv -----
package apt_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = ($clog2(MAX_POINTS + 1) > 11) ? $clog2(MAX_POINTS + 1) : 11;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [63:0] FP_ZERO = 64'h0000000000000000;
    localparam logic [63:0] FP_HALF = 64'h3FE0000000000000;
    localparam logic [63:0] FP_TWO  = 64'h4000000000000000;
    localparam logic [63:0] FP_QNAN = 64'hFFF8000000000000;

    typedef enum logic [2:0] {
        FOP_ADD,
        FOP_SUB,
        FOP_MUL,
        FOP_DIV,
        FOP_SQRT
    } fpu_op_t;

    typedef struct packed {
        logic    start;
        fpu_op_t op;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } fpu_rsp_t;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  point_index;
        logic [63:0] radius;
        logic [63:0] density;
    } in_item_t;

    typedef struct packed {
        logic [63:0] surface_density;
        logic [9:0]  result_index;
    } out_item_t;

endpackage

// ----- hw/rtl/apt_fpu.sv -----
module apt_fpu
    import apt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  fpu_req_t    req,
    input  logic [63:0] fa,
    input  logic [63:0] fb,
    output fpu_rsp_t    rsp
);

    typedef enum logic [3:0] {
        F_IDLE,
        F_PRENORM,
        F_ADD,
        F_MUL,
        F_DIV,
        F_SQRT,
        F_SQFIN,
        F_NORM,
        F_DONE
    } fstate_t;

    localparam logic signed [13:0] EMIN   = -14'sd1022;
    localparam logic signed [13:0] EFLOOR = -14'sd1082;

    fstate_t            fstate_reg;
    fpu_op_t            op_reg;
    logic               sgn_reg;
    logic               sub_reg;
    logic signed [13:0] ea_reg;
    logic signed [13:0] eb_reg;
    logic [52:0]        ma_reg;
    logic [52:0]        mb_reg;
    logic [57:0]        m_reg;
    logic signed [13:0] e_reg;
    logic [5:0]         cnt_reg;
    logic [105:0]       acc_reg;
    logic [59:0]        rem_reg;
    logic [59:0]        sqs_reg;
    logic [56:0]        q_reg;
    logic [63:0]        res_reg;

    function automatic logic is_nan(input logic [63:0] x);
        return (&x[62:52]) && (|x[51:0]);
    endfunction

    function automatic logic is_inf(input logic [63:0] x);
        return (&x[62:52]) && !(|x[51:0]);
    endfunction

    function automatic logic is_zero(input logic [63:0] x);
        return x[62:0] == 63'd0;
    endfunction

    function automatic logic signed [13:0] raw_exp(input logic [63:0] x);
        return (x[62:52] == 11'd0) ? EMIN : ($signed({3'b000, x[62:52]}) - 14'sd1023);
    endfunction

    function automatic logic [52:0] raw_man(input logic [63:0] x);
        return {|x[62:52], x[51:0]};
    endfunction

    // Special operands resolve at once; everything else runs the iterative paths.
    logic [63:0] bx;
    logic        a_ge_b;
    logic        special;
    logic [63:0] sres;

    always_comb begin
        bx      = (req.op == FOP_SUB) ? {~fb[63], fb[62:0]} : fb;
        a_ge_b  = fa[62:0] >= fb[62:0];
        special = 1'b1;
        sres    = FP_QNAN;
        case (req.op)
            FOP_ADD, FOP_SUB: begin
                if (is_nan(fa)) begin
                    sres = fa | 64'h0008000000000000;
                end else if (is_nan(fb)) begin
                    sres = fb | 64'h0008000000000000;
                end else if (is_inf(fa) && is_inf(fb)) begin
                    sres = (fa[63] == bx[63]) ? fa : FP_QNAN;
                end else if (is_inf(fa)) begin
                    sres = fa;
                end else if (is_inf(fb)) begin
                    sres = bx;
                end else if (is_zero(fa) && is_zero(fb)) begin
                    sres = {fa[63] & bx[63], 63'd0};
                end else if (is_zero(fa)) begin
                    sres = bx;
                end else if (is_zero(fb)) begin
                    sres = fa;
                end else begin
                    special = 1'b0;
                end
            end
            FOP_MUL: begin
                if (is_nan(fa)) begin
                    sres = fa | 64'h0008000000000000;
                end else if (is_nan(fb)) begin
                    sres = fb | 64'h0008000000000000;
                end else if ((is_inf(fa) && is_zero(fb)) || (is_zero(fa) && is_inf(fb))) begin
                    sres = FP_QNAN;
                end else if (is_inf(fa) || is_inf(fb)) begin
                    sres = {fa[63] ^ fb[63], 11'h7FF, 52'd0};
                end else if (is_zero(fa) || is_zero(fb)) begin
                    sres = {fa[63] ^ fb[63], 63'd0};
                end else begin
                    special = 1'b0;
                end
            end
            FOP_DIV: begin
                if (is_nan(fa)) begin
                    sres = fa | 64'h0008000000000000;
                end else if (is_nan(fb)) begin
                    sres = fb | 64'h0008000000000000;
                end else if (is_zero(fb)) begin
                    sres = is_zero(fa) ? FP_QNAN : {fa[63] ^ fb[63], 11'h7FF, 52'd0};
                end else if (is_inf(fa) && is_inf(fb)) begin
                    sres = FP_QNAN;
                end else if (is_inf(fa)) begin
                    sres = {fa[63] ^ fb[63], 11'h7FF, 52'd0};
                end else if (is_inf(fb) || is_zero(fa)) begin
                    sres = {fa[63] ^ fb[63], 63'd0};
                end else begin
                    special = 1'b0;
                end
            end
            FOP_SQRT: begin
                if (is_nan(fa)) begin
                    sres = fa | 64'h0008000000000000;
                end else if (is_inf(fa)) begin
                    sres = fa[63] ? FP_QNAN : fa;
                end else if (is_zero(fa)) begin
                    sres = fa;
                end else if (fa[63]) begin
                    sres = FP_QNAN;
                end else begin
                    special = 1'b0;
                end
            end
            default: begin
                sres = FP_QNAN;
            end
        endcase
    end

    // Alignment and add or subtract of the larger and smaller magnitudes.
    logic signed [13:0] add_d;
    logic [57:0]        add_a;
    logic [57:0]        add_bf;
    logic [57:0]        add_mask;
    logic [57:0]        add_bs;
    logic [57:0]        add_m;

    always_comb begin
        add_d    = ea_reg - eb_reg;
        add_a    = {2'b00, ma_reg, 3'b000};
        add_bf   = {2'b00, mb_reg, 3'b000};
        add_mask = (58'd1 << add_d[5:0]) - 58'd1;
        if (add_d > 14'sd57) begin
            add_bs = {57'd0, |mb_reg};
        end else begin
            add_bs = (add_bf >> add_d[5:0]) | {57'd0, |(add_bf & add_mask)};
        end
        add_m = sub_reg ? (add_a - add_bs) : (add_a + add_bs);
    end

    // One restoring square root step.
    logic [59:0] sq_bit;
    logic [59:0] sq_t;

    always_comb begin
        sq_bit = 60'd1 << cnt_reg;
        sq_t   = sqs_reg + sq_bit;
    end

    // Square root rounding and packing.
    logic [53:0]        sq_mant;
    logic               sq_inc;
    logic signed [13:0] sq_half;
    logic signed [13:0] sq_be;
    logic [51:0]        sq_frac;

    always_comb begin
        sq_inc  = q_reg[0] && ((rem_reg != 60'd0) || q_reg[1]);
        sq_mant = {1'b0, q_reg[53:1]} + {53'd0, sq_inc};
        sq_half = e_reg >>> 1;
        if (sq_mant[53]) begin
            sq_frac = sq_mant[52:1];
            sq_be   = sq_half + 14'sd1024;
        end else begin
            sq_frac = sq_mant[51:0];
            sq_be   = sq_half + 14'sd1023;
        end
    end

    // Round to nearest even and pack.
    logic               rn_inc;
    logic [53:0]        rn_m;
    logic [51:0]        rn_frac;
    logic signed [13:0] rn_exp;
    logic               rn_hid;
    logic signed [13:0] rn_be;
    logic [63:0]        rn_res;

    always_comb begin
        rn_inc = m_reg[2] & (m_reg[1] | m_reg[0] | m_reg[3]);
        rn_m   = {1'b0, m_reg[55:3]} + {53'd0, rn_inc};
        if (rn_m[53]) begin
            rn_frac = rn_m[52:1];
            rn_exp  = e_reg + 14'sd1;
            rn_hid  = 1'b1;
        end else begin
            rn_frac = rn_m[51:0];
            rn_exp  = e_reg;
            rn_hid  = rn_m[52];
        end
        rn_be = rn_hid ? (rn_exp + 14'sd1023) : 14'sd0;
        if (rn_be >= 14'sd2047) begin
            rn_res = {sgn_reg, 11'h7FF, 52'd0};
        end else begin
            rn_res = {sgn_reg, rn_be[10:0], rn_frac};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg <= F_IDLE;
        end else begin
            case (fstate_reg)
                F_IDLE: begin
                    if (req.start) begin
                        op_reg <= req.op;
                        if (special) begin
                            res_reg    <= sres;
                            fstate_reg <= F_DONE;
                        end else if (req.op == FOP_ADD || req.op == FOP_SUB) begin
                            sub_reg <= fa[63] ^ bx[63];
                            if (a_ge_b) begin
                                sgn_reg <= fa[63];
                                ea_reg  <= raw_exp(fa);
                                ma_reg  <= raw_man(fa);
                                eb_reg  <= raw_exp(fb);
                                mb_reg  <= raw_man(fb);
                            end else begin
                                sgn_reg <= bx[63];
                                ea_reg  <= raw_exp(fb);
                                ma_reg  <= raw_man(fb);
                                eb_reg  <= raw_exp(fa);
                                mb_reg  <= raw_man(fa);
                            end
                            fstate_reg <= F_ADD;
                        end else begin
                            sgn_reg    <= fa[63] ^ fb[63];
                            ea_reg     <= raw_exp(fa);
                            ma_reg     <= raw_man(fa);
                            eb_reg     <= raw_exp(fb);
                            mb_reg     <= raw_man(fb);
                            fstate_reg <= F_PRENORM;
                        end
                    end
                end
                F_PRENORM: begin
                    // Subnormal operands are shifted up one bit a cycle.
                    if (!ma_reg[52]) begin
                        ma_reg <= {ma_reg[51:0], 1'b0};
                        ea_reg <= ea_reg - 14'sd1;
                    end else if (op_reg != FOP_SQRT && !mb_reg[52]) begin
                        mb_reg <= {mb_reg[51:0], 1'b0};
                        eb_reg <= eb_reg - 14'sd1;
                    end else begin
                        q_reg <= 57'd0;
                        case (op_reg)
                            FOP_MUL: begin
                                acc_reg    <= 106'd0;
                                cnt_reg    <= 6'd0;
                                fstate_reg <= F_MUL;
                            end
                            FOP_DIV: begin
                                rem_reg    <= {7'd0, ma_reg};
                                cnt_reg    <= 6'd0;
                                fstate_reg <= F_DIV;
                            end
                            default: begin
                                if (ea_reg[0]) begin
                                    rem_reg <= {5'd0, ma_reg, 2'b00};
                                    e_reg   <= ea_reg - 14'sd1;
                                end else begin
                                    rem_reg <= {6'd0, ma_reg, 1'b0};
                                    e_reg   <= ea_reg;
                                end
                                sqs_reg    <= 60'd0;
                                cnt_reg    <= 6'd53;
                                fstate_reg <= F_SQRT;
                            end
                        endcase
                    end
                end
                F_ADD: begin
                    m_reg <= add_m;
                    e_reg <= ea_reg;
                    if (add_m == 58'd0) begin
                        sgn_reg <= 1'b0;
                    end
                    fstate_reg <= F_NORM;
                end
                F_MUL: begin
                    if (cnt_reg == 6'd53) begin
                        m_reg      <= {1'b0, acc_reg[105:50], acc_reg[49] | (|acc_reg[48:0])};
                        e_reg      <= ea_reg + eb_reg;
                        fstate_reg <= F_NORM;
                    end else begin
                        acc_reg <= {acc_reg[104:0], 1'b0} + (ma_reg[52] ? {53'd0, mb_reg} : 106'd0);
                        ma_reg  <= {ma_reg[51:0], 1'b0};
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                F_DIV: begin
                    if (cnt_reg == 6'd57) begin
                        m_reg      <= {q_reg, |rem_reg};
                        e_reg      <= ea_reg - eb_reg - 14'sd2;
                        fstate_reg <= F_NORM;
                    end else begin
                        if (rem_reg >= {7'd0, mb_reg}) begin
                            rem_reg <= {rem_reg[58:0] - {6'd0, mb_reg}, 1'b0};
                            q_reg   <= {q_reg[55:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[58:0], 1'b0};
                            q_reg   <= {q_reg[55:0], 1'b0};
                        end
                        cnt_reg <= cnt_reg + 6'd1;
                    end
                end
                F_SQRT: begin
                    if (sq_t <= rem_reg) begin
                        sqs_reg <= sq_t + sq_bit;
                        rem_reg <= {rem_reg[58:0] - sq_t[58:0], 1'b0};
                        q_reg   <= q_reg + sq_bit[56:0];
                    end else begin
                        rem_reg <= {rem_reg[58:0], 1'b0};
                    end
                    if (cnt_reg == 6'd0) begin
                        fstate_reg <= F_SQFIN;
                    end else begin
                        cnt_reg <= cnt_reg - 6'd1;
                    end
                end
                F_SQFIN: begin
                    res_reg    <= {1'b0, sq_be[10:0], sq_frac};
                    fstate_reg <= F_DONE;
                end
                F_NORM: begin
                    if (m_reg[57:56] != 2'b00) begin
                        m_reg <= {1'b0, m_reg[57:2], m_reg[1] | m_reg[0]};
                        e_reg <= e_reg + 14'sd1;
                    end else if (e_reg < EFLOOR) begin
                        // Far below the subnormal range only the sticky bit survives.
                        m_reg <= {57'd0, |m_reg};
                        e_reg <= EMIN;
                    end else if (e_reg < EMIN) begin
                        m_reg <= {1'b0, m_reg[57:2], m_reg[1] | m_reg[0]};
                        e_reg <= e_reg + 14'sd1;
                    end else if (!m_reg[55] && (m_reg != 58'd0) && (e_reg > EMIN)) begin
                        m_reg <= {m_reg[56:0], 1'b0};
                        e_reg <= e_reg - 14'sd1;
                    end else begin
                        res_reg    <= rn_res;
                        fstate_reg <= F_DONE;
                    end
                end
                F_DONE: begin
                    fstate_reg <= F_IDLE;
                end
                default: begin
                    fstate_reg <= F_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = (fstate_reg == F_DONE);
    assign rsp.result = res_reg;

endmodule

// ----- hw/rtl/abel_projection_trapezoid.sv -----
// Channel   Direction  Handshake              Payload
// s_        in         s_valid / s_ready      in_item_t  (cmd, point_index, radius, density)
// m_        out        m_valid / m_ready      out_item_t (surface_density, result_index)
// cfg_      in         cfg_valid / cfg_ready  point_count, 11 bits
//
// A load is written into the sample stores as it is accepted. A query walks the
// segments from its index out to the outermost point in use, on the one shared
// floating point unit whose multiply, divide and square root each work one bit a
// cycle; cancellation in a subtraction and subnormal operands are shifted one bit
// a cycle as well. An index at or past the outermost point answers zero.
// Reset is synchronous and active low; the sample stores are not cleared.
// A result waits in the output register while further loads are taken.
module abel_projection_trapezoid
    import apt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_P_II,
        ST_P_A,
        ST_P_D,
        ST_P_S,
        ST_P_2,
        ST_P_H,
        ST_P_DN,
        ST_P_T,
        ST_P_SG,
        ST_I_RR,
        ST_I_D,
        ST_I_SQ,
        ST_I_N1,
        ST_I_N2,
        ST_I_DV,
        ST_C_W,
        ST_C_S,
        ST_C_H,
        ST_C_M,
        ST_C_A,
        ST_SEG_NEXT,
        ST_SEG_CHK,
        ST_SEG_RD_A,
        ST_SEG_RD_B,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        D_II,
        D_TMP,
        D_TMP2,
        D_SIGMA,
        D_FCUR
    } dst_t;

    logic [63:0] radius_mem  [MAX_POINTS];
    logic [63:0] density_mem [MAX_POINTS];

    state_t      state_reg;
    logic        issued_reg;
    logic        first_reg;
    logic [10:0] point_count_reg;
    logic [AW-1:0] raddr_reg;
    logic [63:0] rd_r_reg;
    logic [63:0] rd_d_reg;
    logic [9:0]  idx_reg;
    logic [AW-1:0] j_reg;
    logic [63:0] r1_reg;
    logic [63:0] r2_reg;
    logic [63:0] rho1_reg;
    logic [63:0] rho2_reg;
    logic [63:0] ii_reg;
    logic [63:0] tmp_reg;
    logic [63:0] tmp2_reg;
    logic [63:0] fprev_reg;
    logic [63:0] fcur_reg;
    logic [63:0] sigma_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic [NW-1:0] pc_w;
    logic [NW-1:0] n_w;
    logic          accept;
    logic          load_we;

    fpu_req_t    freq;
    fpu_rsp_t    frsp;
    logic [63:0] fa;
    logic [63:0] fb;
    logic        op_state;
    dst_t        fdst;
    state_t      fnext;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign accept    = s_valid && s_ready;
    assign load_we   = accept && (s_data.cmd == CMD_LOAD)
                       && (NW'(s_data.point_index) < NW'(MAX_POINTS));

    always_comb begin
        pc_w = NW'(point_count_reg);
        if (pc_w < NW'(2)) begin
            n_w = NW'(2);
        end else if (pc_w > NW'(MAX_POINTS)) begin
            n_w = NW'(MAX_POINTS);
        end else begin
            n_w = pc_w;
        end
    end

    // Operation, operands, destination and follow-on state of each arithmetic step.
    always_comb begin
        op_state = 1'b1;
        freq.op  = FOP_ADD;
        fa       = FP_ZERO;
        fb       = FP_ZERO;
        fdst     = D_TMP;
        fnext    = ST_IDLE;
        case (state_reg)
            ST_P_II: begin
                freq.op = FOP_MUL; fa = r1_reg; fb = r1_reg; fdst = D_II; fnext = ST_P_A;
            end
            ST_P_A: begin
                freq.op = FOP_MUL; fa = r2_reg; fb = r2_reg; fnext = ST_P_D;
            end
            ST_P_D: begin
                freq.op = FOP_SUB; fa = tmp_reg; fb = ii_reg; fnext = ST_P_S;
            end
            ST_P_S: begin
                freq.op = FOP_SQRT; fa = tmp_reg; fnext = ST_P_2;
            end
            ST_P_2: begin
                freq.op = FOP_MUL; fa = FP_TWO; fb = tmp_reg; fnext = ST_P_H;
            end
            ST_P_H: begin
                freq.op = FOP_MUL; fa = tmp_reg; fb = FP_HALF; fnext = ST_P_DN;
            end
            ST_P_DN: begin
                freq.op = FOP_ADD; fa = rho2_reg; fb = rho1_reg; fdst = D_TMP2;
                fnext = ST_P_T;
            end
            ST_P_T: begin
                freq.op = FOP_MUL; fa = tmp_reg; fb = tmp2_reg; fnext = ST_P_SG;
            end
            ST_P_SG: begin
                freq.op = FOP_ADD; fa = FP_ZERO; fb = tmp_reg; fdst = D_SIGMA;
                fnext = ST_I_RR;
            end
            ST_I_RR: begin
                freq.op = FOP_MUL; fa = r2_reg; fb = r2_reg; fnext = ST_I_D;
            end
            ST_I_D: begin
                freq.op = FOP_SUB; fa = tmp_reg; fb = ii_reg; fnext = ST_I_SQ;
            end
            ST_I_SQ: begin
                freq.op = FOP_SQRT; fa = tmp_reg; fnext = ST_I_N1;
            end
            ST_I_N1: begin
                freq.op = FOP_MUL; fa = rho2_reg; fb = FP_TWO; fdst = D_TMP2;
                fnext = ST_I_N2;
            end
            ST_I_N2: begin
                freq.op = FOP_MUL; fa = tmp2_reg; fb = r2_reg; fdst = D_TMP2;
                fnext = ST_I_DV;
            end
            ST_I_DV: begin
                freq.op = FOP_DIV; fa = tmp2_reg; fb = tmp_reg; fdst = D_FCUR;
                fnext = first_reg ? ST_SEG_NEXT : ST_C_W;
            end
            ST_C_W: begin
                freq.op = FOP_SUB; fa = r2_reg; fb = r1_reg; fnext = ST_C_S;
            end
            ST_C_S: begin
                freq.op = FOP_ADD; fa = fprev_reg; fb = fcur_reg; fdst = D_TMP2;
                fnext = ST_C_H;
            end
            ST_C_H: begin
                freq.op = FOP_MUL; fa = FP_HALF; fb = tmp_reg; fnext = ST_C_M;
            end
            ST_C_M: begin
                freq.op = FOP_MUL; fa = tmp_reg; fb = tmp2_reg; fnext = ST_C_A;
            end
            ST_C_A: begin
                freq.op = FOP_ADD; fa = sigma_reg; fb = tmp_reg; fdst = D_SIGMA;
                fnext = ST_SEG_NEXT;
            end
            default: begin
                op_state = 1'b0;
            end
        endcase
        freq.start = op_state && !issued_reg;
    end

    apt_fpu u_fpu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (freq),
        .fa      (fa),
        .fb      (fb),
        .rsp     (frsp)
    );

    always_ff @(posedge aclk) begin
        if (load_we) begin
            radius_mem[AW'(s_data.point_index)]  <= s_data.radius;
            density_mem[AW'(s_data.point_index)] <= s_data.density;
        end
        rd_r_reg <= radius_mem[raddr_reg];
        rd_d_reg <= density_mem[raddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            issued_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
            point_count_reg <= 11'd1024;
        end else begin
            if (cfg_valid) begin
                point_count_reg <= cfg_data;
            end
            // In the done state the output register is handled by the state itself.
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            if (op_state) begin
                if (!issued_reg) begin
                    issued_reg <= 1'b1;
                end else if (frsp.done) begin
                    issued_reg <= 1'b0;
                    case (fdst)
                        D_II:    ii_reg    <= frsp.result;
                        D_TMP:   tmp_reg   <= frsp.result;
                        D_TMP2:  tmp2_reg  <= frsp.result;
                        D_SIGMA: sigma_reg <= frsp.result;
                        D_FCUR:  fcur_reg  <= frsp.result;
                        default: tmp_reg   <= frsp.result;
                    endcase
                    state_reg <= fnext;
                end
            end else begin
                case (state_reg)
                    ST_IDLE: begin
                        if (accept && s_data.cmd == CMD_QUERY) begin
                            idx_reg <= s_data.point_index;
                            if (NW'(s_data.point_index) + NW'(1) < n_w) begin
                                raddr_reg <= AW'(s_data.point_index);
                                state_reg <= ST_RD_A;
                            end else begin
                                sigma_reg <= FP_ZERO;
                                state_reg <= ST_DONE;
                            end
                        end
                    end
                    ST_RD_A: begin
                        raddr_reg <= AW'(idx_reg) + AW'(1);
                        state_reg <= ST_RD_B;
                    end
                    ST_RD_B: begin
                        r1_reg    <= rd_r_reg;
                        rho1_reg  <= rd_d_reg;
                        state_reg <= ST_RD_C;
                    end
                    ST_RD_C: begin
                        r2_reg    <= rd_r_reg;
                        rho2_reg  <= rd_d_reg;
                        j_reg     <= AW'(idx_reg);
                        first_reg <= 1'b1;
                        state_reg <= ST_P_II;
                    end
                    ST_SEG_NEXT: begin
                        // The outer integrand value of this segment is the inner one of the next.
                        fprev_reg <= fcur_reg;
                        r1_reg    <= r2_reg;
                        j_reg     <= j_reg + AW'(1);
                        first_reg <= 1'b0;
                        state_reg <= ST_SEG_CHK;
                    end
                    ST_SEG_CHK: begin
                        if (NW'(j_reg) + NW'(1) < n_w) begin
                            raddr_reg <= j_reg + AW'(1);
                            state_reg <= ST_SEG_RD_A;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end
                    ST_SEG_RD_A: begin
                        state_reg <= ST_SEG_RD_B;
                    end
                    ST_SEG_RD_B: begin
                        r2_reg    <= rd_r_reg;
                        rho2_reg  <= rd_d_reg;
                        state_reg <= ST_I_RR;
                    end
                    ST_DONE: begin
                        if (!m_valid_reg || m_ready) begin
                            m_valid_reg                <= 1'b1;
                            m_data_reg.surface_density <= sigma_reg;
                            m_data_reg.result_index    <= idx_reg;
                            state_reg                  <= ST_IDLE;
                        end
                    end
                    default: begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

endmodule
